// File: design/wssd_pkg.sv
// Shared constants and types for the windowed slope stability detector.
package wssd_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;
    localparam int WIN_LEN_W  = 7;
    localparam int FRAC_W     = 24;
    localparam int FRAC_SHIFT = 24;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STABILITY_FRACTION = 1'b1;

    localparam logic [WIN_LEN_W-1:0] WIN_LEN_RESET = 7'd10;
    localparam logic [FRAC_W-1:0]    FRAC_RESET    = 24'd167772;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// File: design/wssd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wssd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/wssd_div.sv
// Restoring divider, one quotient bit per cycle.
module wssd_div #(
    parameter int NUM_W = 70,
    parameter int DEN_W = 22
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [NUM_W-1:0]          num,
    input  logic [DEN_W-1:0]          den,
    output logic [NUM_W-1:0]          quot,
    output wssd_pkg::div_status_t     status
);
    import wssd_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] work_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] work_next;

    always_comb begin
        trial     = {rem_reg, work_reg[NUM_W-1]};
        ge        = trial >= {1'b0, den_reg};
        rem_next  = ge ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
        work_next = {work_reg[NUM_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(NUM_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            work_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end else if (busy_reg) begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign quot        = work_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// File: design/windowed_slope_stability_detector.sv
// Top level: sliding-window least-squares slope with stability flag.
//
// Usage:
//  - s_ channel: one energy sample per request (s_tdata, signed, 16 fraction
//    bits). s_tready is high only while the sequencer is idle.
//  - m_ channel: one result per sample. m_tdata carries the slope, m_tuser
//    carries is_stable (bit 0) and enough_points (bit 1).
//  - cfg port: cfg_wr_en/cfg_addr/cfg_wr_data; index 0 window_length,
//    index 1 stability_fraction. Write only while idle.
//  - Sequence, from the accepting edge: with too few samples, the sequencer
//    goes straight to its final state. Otherwise it walks W ring entries
//    through the RAM read port and one shared MAC, drains the MAC pipeline,
//    runs NUM_W divider steps (one quotient bit a cycle,
//    NUM_W = SAMPLE_WIDTH + 2*clog2(MAX+1) + 5, 67 by default), sees the
//    divider finish and loads the result. The threshold product runs
//    bit-serially beside the divider.
//  - One sample at a time: s_tready returns in the same cycle that m_tvalid
//    rises; a new sample may be taken while the previous result still waits
//    in the output register.
//  - Reset (aresetn low, synchronous): ring position and sample count
//    cleared, registers back to their defaults, output invalid. The ring
//    contents are not cleared; unwritten entries are never read.
//  - A stalled receiver holds the result in the output register; the
//    sequencer then waits in its final state before going idle.
module windowed_slope_stability_detector #(
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_WIDTH = 48,
    localparam int TDW = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [wssd_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [wssd_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [TDW-1:0]                    s_tdata,   // [SW-1:0] energy_sample
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [TDW-1:0]                    m_tdata,   // [SW-1:0] slope
    output logic [1:0]                        m_tuser    // [0] is_stable, [1] enough_points
);
    import wssd_pkg::*;

    localparam int SW   = SAMPLE_WIDTH;
    localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW   = $clog2(MAX_WINDOW + 1);
    localparam int XW   = (CW > WIN_LEN_W) ? CW : WIN_LEN_W;
    localparam int CFW  = CW + 2;               // coefficient 2k-(W-1)
    localparam int PW   = SW + CFW;             // coefficient * sample
    localparam int NSW  = SW + 2 * CW;          // weighted sum
    localparam int SSW  = SW + CW;              // plain sum
    localparam int SIXW = NSW + 3;              // 6|N|
    localparam int NUMW = NSW + 5;              // 12|N| + D
    localparam int DW   = 3 * CW;               // D = (W*W-1)*W
    localparam int DENW = DW + 1;               // 2D
    localparam int P1W  = 2 * CW;               // W*W-1
    localparam int TW   = P1W + FRAC_W;         // fraction * (W*W-1)
    localparam int TCW  = $clog2(TW + 1);
    localparam int LW   = SIXW + FRAC_SHIFT;
    localparam int RW   = SSW + TW;
    localparam int CMPW = (LW > RW) ? LW : RW;

    localparam logic [NUMW-1:0] LIM_POS = (NUMW'(1) << (SW - 1)) - NUMW'(1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ISSUE = 5'b00010,
        S_DRAIN = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    // control
    state_t                 state_reg;
    logic [AW-1:0]          wp_reg;
    logic [CW-1:0]          seen_reg;
    logic                   v1_reg, v2_reg;
    logic                   m_tvalid_reg;
    logic [WIN_LEN_W-1:0]   win_len_reg;
    logic [FRAC_W-1:0]      frac_reg;
    logic [TCW-1:0]         mul_cnt_reg;

    // datapath
    logic [CW-1:0]          w_reg;
    logic [CW-1:0]          k_reg;
    logic [AW-1:0]          rd_ptr_reg;
    logic signed [CFW-1:0]  c1_reg;
    logic signed [PW-1:0]   prod_reg;
    logic signed [SW-1:0]   y2_reg;
    logic signed [NSW-1:0]  n_acc_reg;
    logic signed [SSW-1:0]  s_acc_reg;
    logic [P1W-1:0]         p1_reg;
    logic [DW-1:0]          d_reg;
    logic [TW-1:0]          t_reg;
    logic [SIXW-1:0]        six_reg;
    logic [SSW-1:0]         smag_reg;
    logic                   n_neg_reg;
    logic [RW-1:0]          mul_acc_reg;
    logic [TW-1:0]          mul_t_reg;
    logic [SW-1:0]          res_slope_reg;
    logic                   res_stable_reg;
    logic                   res_enough_reg;
    logic [SW-1:0]          m_slope_reg;
    logic [1:0]             m_flags_reg;

    logic                   in_fire;
    logic [XW-1:0]          wl_x;
    logic [CW-1:0]          w_eff;
    logic [CW-1:0]          seen_inc;
    logic [AW-1:0]          wp_inc;
    logic [CW:0]            start_sum;
    logic [AW-1:0]          rd_start;
    logic [AW-1:0]          rd_ptr_inc;
    logic signed [CFW-1:0]  coef;
    logic                   drained;
    logic                   div_start;
    logic [NSW-1:0]         nmag;
    logic [SSW-1:0]         smag;
    logic [SIXW-1:0]        six;
    logic [NUMW-1:0]        div_num;
    logic [DENW-1:0]        div_den;
    logic [NUMW-1:0]        div_quot;
    div_status_t            div_status;
    logic [NUMW-1:0]        lim;
    logic [NUMW-1:0]        q_sat;
    logic [SW-1:0]          slope_val;
    logic                   stable_val;
    logic                   fin_fire;
    logic                   out_free;
    logic [SW-1:0]          ram_q;

    assign in_fire  = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        // effective window, clamped to [2, MAX_WINDOW]
        wl_x = XW'(win_len_reg);
        if (wl_x < XW'(2)) begin
            w_eff = CW'(2);
        end else if (wl_x > XW'(MAX_WINDOW)) begin
            w_eff = CW'(MAX_WINDOW);
        end else begin
            w_eff = CW'(wl_x);
        end

        seen_inc = (seen_reg == CW'(MAX_WINDOW)) ? seen_reg : seen_reg + CW'(1);
        wp_inc   = (wp_reg == AW'(MAX_WINDOW - 1)) ? '0 : wp_reg + AW'(1);

        // oldest sample of the window
        start_sum = (CW + 1)'(wp_inc) + (CW + 1)'(MAX_WINDOW) - (CW + 1)'(w_eff);
        if (start_sum >= (CW + 1)'(MAX_WINDOW)) begin
            start_sum = start_sum - (CW + 1)'(MAX_WINDOW);
        end
        rd_start = AW'(start_sum);

        rd_ptr_inc = (rd_ptr_reg == AW'(MAX_WINDOW - 1)) ? '0 : rd_ptr_reg + AW'(1);
        coef = CFW'({k_reg, 1'b0}) - CFW'(w_reg) + CFW'(1);

        drained   = !v1_reg && !v2_reg;
        div_start = (state_reg == S_DRAIN) && drained;

        nmag    = n_acc_reg[NSW-1] ? NSW'(-n_acc_reg) : NSW'(n_acc_reg);
        smag    = s_acc_reg[SSW-1] ? SSW'(-s_acc_reg) : SSW'(s_acc_reg);
        six     = (SIXW'(nmag) << 2) + (SIXW'(nmag) << 1);
        div_num = (NUMW'(six) << 1) + NUMW'(d_reg);
        div_den = {d_reg, 1'b0};

        // saturate, then restore sign
        lim       = LIM_POS + NUMW'(n_neg_reg);
        q_sat     = (div_quot > lim) ? lim : div_quot;
        slope_val = n_neg_reg ? SW'(~q_sat + NUMW'(1)) : SW'(q_sat);
        stable_val = (CMPW'(six_reg) << FRAC_SHIFT) < CMPW'(mul_acc_reg);

        fin_fire = (state_reg == S_DIV) && div_status.done && !div_status.busy
                   && (mul_cnt_reg == '0);
    end

    wssd_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (in_fire),
        .wr_addr (wp_reg),
        .wr_data (s_tdata[SW-1:0]),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_q)
    );

    wssd_div #(
        .NUM_W (NUMW),
        .DEN_W (DENW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .quot    (div_quot),
        .status  (div_status)
    );

    // sequencer and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            wp_reg       <= '0;
            seen_reg     <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            win_len_reg  <= WIN_LEN_RESET;
            frac_reg     <= FRAC_RESET;
            mul_cnt_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_WINDOW_LENGTH:      win_len_reg <= cfg_wr_data[WIN_LEN_W-1:0];
                    REG_STABILITY_FRACTION: frac_reg    <= cfg_wr_data[FRAC_W-1:0];
                    default: ;
                endcase
            end

            v1_reg <= (state_reg == S_ISSUE);
            v2_reg <= v1_reg;
            // load a new result when free, otherwise hold until taken
            m_tvalid_reg <= ((state_reg == S_DONE) && out_free)
                            || (m_tvalid_reg && !m_tready);

            unique case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        wp_reg   <= wp_inc;
                        seen_reg <= seen_inc;
                        state_reg <= (seen_inc >= w_eff) ? S_ISSUE : S_DONE;
                    end
                end
                S_ISSUE: begin
                    if (k_reg == w_reg - CW'(1)) begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (drained) begin
                        mul_cnt_reg <= TCW'(TW);
                        state_reg   <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (mul_cnt_reg != '0) begin
                        mul_cnt_reg <= mul_cnt_reg - TCW'(1);
                    end
                    if (fin_fire) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        // window constants: p1_reg from w_reg, then d_reg and t_reg from p1_reg
        p1_reg <= P1W'((P1W'(w_reg) - P1W'(1)) * (P1W'(w_reg) + P1W'(1)));
        d_reg  <= DW'(DW'(p1_reg) * DW'(w_reg));
        t_reg  <= TW'(TW'(p1_reg) * TW'(frac_reg));

        // MAC pipeline: RAM read, multiply, accumulate
        prod_reg <= PW'(c1_reg) * PW'($signed(ram_q));
        y2_reg   <= $signed(ram_q);
        if (v2_reg) begin
            n_acc_reg <= n_acc_reg + NSW'(prod_reg);
            s_acc_reg <= s_acc_reg + SSW'(y2_reg);
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    w_reg          <= w_eff;
                    rd_ptr_reg     <= rd_start;
                    k_reg          <= '0;
                    n_acc_reg      <= '0;
                    s_acc_reg      <= '0;
                    res_slope_reg  <= '0;
                    res_stable_reg <= 1'b0;
                    res_enough_reg <= 1'b0;
                end
            end
            S_ISSUE: begin
                c1_reg     <= coef;
                rd_ptr_reg <= rd_ptr_inc;
                k_reg      <= k_reg + CW'(1);
            end
            S_DRAIN: begin
                if (drained) begin
                    six_reg     <= six;
                    smag_reg    <= smag;
                    n_neg_reg   <= n_acc_reg[NSW-1];
                    mul_acc_reg <= '0;
                    mul_t_reg   <= t_reg;
                end
            end
            S_DIV: begin
                // bit-serial |sum| * fraction * (W*W-1), MSB first
                if (mul_cnt_reg != '0) begin
                    mul_acc_reg <= (mul_acc_reg << 1)
                                 + (mul_t_reg[TW-1] ? RW'(smag_reg) : RW'(0));
                    mul_t_reg   <= mul_t_reg << 1;
                end
                if (fin_fire) begin
                    res_slope_reg  <= slope_val;
                    res_stable_reg <= stable_val;
                    res_enough_reg <= 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_slope_reg <= res_slope_reg;
                    m_flags_reg <= {res_enough_reg, res_stable_reg};
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDW'(m_slope_reg);
    assign m_tuser  = m_flags_reg;

endmodule
